// ===== hw/rtl/csa_pkg.sv =====
// Shared types and constants for the curvature steering angle unit.
// No dependencies.
`default_nettype none
package csa_pkg;
   localparam int SAMPLE_W   = 8;
   localparam int ERR_W      = 9;
   localparam int ROOT_ARG_W = 17;
   localparam int SQRT_STEPS = 9;
   localparam int ROOT_W     = 8;
   localparam int PROD_W     = 24;
   localparam int AREA_W     = 12;
   localparam int GAIN_W     = 27;
   localparam int DGAIN_W    = 10;
   localparam int CENTER_W   = 16;
   localparam int THRESH_W   = 8;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_CENTER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRAIGHT_TH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEND_TH      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN   = 2'd3;

   typedef enum logic [1:0] {
      GAIN_X1P5 = 2'd0,
      GAIN_X3   = 2'd1,
      GAIN_X4P5 = 2'd2
   } gain_sel_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      logic signed [ERR_W-1:0] err_prev;
      gain_sel_type            gsel;
      logic [AREA_W-1:0]       area;
   } side_type;
endpackage
`default_nettype wire

// ===== hw/rtl/csa_sqrt_cell.sv =====
// One digit step of the floor square root chain.
// Depends on csa_pkg.
`default_nettype none
module csa_sqrt_cell import csa_pkg::*; #(
   parameter int BIT_POS = 0
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [ROOT_ARG_W-1:0] v_in,
   input  wire logic [ROOT_ARG_W-1:0] root_in,
   output logic      [ROOT_ARG_W-1:0] v_ff,
   output logic      [ROOT_ARG_W-1:0] root_ff
);
   localparam int RW = ROOT_ARG_W + 1;
   localparam logic [RW-1:0] BIT_VAL = RW'(1) << BIT_POS;

   logic [RW-1:0]         trial;
   logic [ROOT_ARG_W-1:0] v_in_n, root_in_n;

   always_comb begin
      trial = {1'b0, root_in} + BIT_VAL;
      if ({1'b0, v_in} >= trial) begin
         v_in_n    = v_in - trial[ROOT_ARG_W-1:0];
         root_in_n = (root_in >> 1) + BIT_VAL[ROOT_ARG_W-1:0];
      end else begin
         v_in_n    = v_in;
         root_in_n = root_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff    <= v_in_n;
         root_ff <= root_in_n;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/csa_div_cell.sv =====
// One quotient bit of the restoring divider chain.
// Depends on csa_pkg.
`default_nettype none
module csa_div_cell import csa_pkg::*; #(
   parameter int BIT_IDX = 0
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [PROD_W-1:0] num_in,
   input  wire logic [AREA_W-1:0] den_in,
   input  wire logic [AREA_W-1:0] rem_in,
   input  wire logic [PROD_W-1:0] quo_in,
   output logic      [PROD_W-1:0] num_ff,
   output logic      [AREA_W-1:0] den_ff,
   output logic      [AREA_W-1:0] rem_ff,
   output logic      [PROD_W-1:0] quo_ff
);
   logic [AREA_W:0]   trial;
   logic [AREA_W-1:0] rem_in_n;
   logic [PROD_W-1:0] quo_in_n;

   always_comb begin
      trial    = {rem_in, num_in[BIT_IDX]};
      quo_in_n = quo_in;
      if (trial >= {1'b0, den_in}) begin
         rem_in_n          = AREA_W'(trial - {1'b0, den_in});
         quo_in_n[BIT_IDX] = 1'b1;
      end else begin
         rem_in_n = trial[AREA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         den_ff <= den_in;
         rem_ff <= rem_in_n;
         quo_ff <= quo_in_n;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/curvature_steering_angle_unit.sv =====
// One beat per cycle sustained while no result waits on rsp_tready.
// The depth is set by the 9-cell square root chains and the 24-cell divider chain.
// The whole pipeline holds when a result waits on rsp_tready.
// Synchronous reset clears valid flags and loads the register reset values.
// Top level; depends on csa_pkg, csa_sqrt_cell, csa_div_cell.
`default_nettype none
module curvature_steering_angle_unit import csa_pkg::*; #(
   parameter int SAMPLE_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // error, error_prev, center_at_row20, 27, 30, 32, 37
   input  wire logic [63:0]          req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // steering_angle, radius_estimate
   output logic      [55:0]          rsp_tdata,
   // saturated
   output logic                      rsp_tuser,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CENTER_W-1:0]  csr_wdata
);
   localparam logic [SAMPLE_W-1:0] SMASK = (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
                                         : SAMPLE_W'((1 << SAMPLE_BITS) - 1);
   localparam int DIV_BASE = SQRT_STEPS + 2;
   localparam int Q_STAGE  = DIV_BASE + PROD_W;
   localparam int DEPTH    = Q_STAGE + 3;

   logic [CENTER_W-1:0] servo_center_ff;
   logic [THRESH_W-1:0] straight_th_ff, bend_th_ff;
   logic [DGAIN_W-1:0]  dgain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_center_ff <= 16'd2825;
         straight_th_ff  <= 8'd3;
         bend_th_ff      <= 8'd12;
         dgain_ff        <= 10'd50;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SERVO_CENTER: servo_center_ff <= csr_wdata;
            CSR_STRAIGHT_TH:  straight_th_ff  <= csr_wdata[THRESH_W-1:0];
            CSR_BEND_TH:      bend_th_ff      <= csr_wdata[THRESH_W-1:0];
            CSR_DERIV_GAIN:   dgain_ff        <= csr_wdata[DGAIN_W-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic vld_ff [0:DEPTH-1];
   side_type sb_ff [0:Q_STAGE+1];
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) vld_ff[i] <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
         rsp_tvalid <= vld_ff[DEPTH-1];
      end
   end

   // stage 0: chord arguments, area, gain class
   logic signed [SAMPLE_W:0]   x1, x2, x3, d21, d31, d23;
   logic signed [13:0]         area_s;
   logic [13:0]                area_abs;
   logic [SAMPLE_W-1:0]        c20, c30, cdiff;
   logic [ROOT_ARG_W-1:0]      a1_in, a2_in, a3_in;
   side_type                   sb_in;

   always_comb begin
      x1  = $signed({1'b0, req_tdata[33:26] & SMASK});
      x2  = $signed({1'b0, req_tdata[49:42] & SMASK});
      x3  = $signed({1'b0, req_tdata[57:50] & SMASK});
      c20 = req_tdata[25:18] & SMASK;
      c30 = req_tdata[41:34] & SMASK;
      d21 = x2 - x1;
      d31 = x3 - x1;
      d23 = x2 - x3;
      area_s   = 14'sd5 * 14'(d31) - 14'sd10 * 14'(d21);
      area_abs = area_s[13] ? 14'(-area_s) : 14'(area_s);
      a1_in = ROOT_ARG_W'(32'(d21) * 32'(d21)) + 17'd25;
      a2_in = ROOT_ARG_W'(32'(d31) * 32'(d31)) + 17'd100;
      a3_in = ROOT_ARG_W'(32'(d23) * 32'(d23)) + 17'd25;
      cdiff = (c20 >= c30) ? c20 - c30 : c30 - c20;
      sb_in.err      = $signed(req_tdata[8:0]);
      sb_in.err_prev = $signed(req_tdata[17:9]);
      sb_in.area     = (area_abs == 14'd0) ? 12'd1 : area_abs[AREA_W-1:0];
      if (cdiff < straight_th_ff)  sb_in.gsel = GAIN_X1P5;
      else if (cdiff < bend_th_ff) sb_in.gsel = GAIN_X3;
      else                         sb_in.gsel = GAIN_X4P5;
   end

   logic [ROOT_ARG_W-1:0] sv_ff [0:2][0:SQRT_STEPS];
   logic [ROOT_ARG_W-1:0] sr_ff [0:2][0:SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         sv_ff[0][0] <= a1_in;
         sv_ff[1][0] <= a2_in;
         sv_ff[2][0] <= a3_in;
         sr_ff[0][0] <= '0;
         sr_ff[1][0] <= '0;
         sr_ff[2][0] <= '0;
         sb_ff[0] <= sb_in;
         for (int i = 1; i <= Q_STAGE + 1; i++) sb_ff[i] <= sb_ff[i-1];
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
         csa_sqrt_cell #(.BIT_POS(2*(SQRT_STEPS-1-k))) u_cell (
            .clock   (clock),
            .en      (en),
            .v_in    (sv_ff[l][k]),
            .root_in (sr_ff[l][k]),
            .v_ff    (sv_ff[l][k+1]),
            .root_ff (sr_ff[l][k+1])
         );
      end
   end

   logic [2*ROOT_W-1:0] p12_ff;
   logic [ROOT_W-1:0]   l3_ff;
   logic [PROD_W-1:0]   prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p12_ff  <= sr_ff[0][SQRT_STEPS][ROOT_W-1:0] * sr_ff[1][SQRT_STEPS][ROOT_W-1:0];
         l3_ff   <= sr_ff[2][SQRT_STEPS][ROOT_W-1:0];
         prod_ff <= PROD_W'(p12_ff) * PROD_W'(l3_ff);
      end
   end

   logic [PROD_W-1:0] dn_ff [0:PROD_W];
   logic [AREA_W-1:0] dd_ff [0:PROD_W];
   logic [AREA_W-1:0] dr_ff [0:PROD_W];
   logic [PROD_W-1:0] dq_ff [0:PROD_W];

   assign dn_ff[0] = prod_ff;
   assign dd_ff[0] = sb_ff[DIV_BASE].area;
   assign dr_ff[0] = '0;
   assign dq_ff[0] = '0;

   for (genvar j = 0; j < PROD_W; j++) begin : g_div
      csa_div_cell #(.BIT_IDX(PROD_W-1-j)) u_cell (
         .clock  (clock),
         .en     (en),
         .num_in (dn_ff[j]),
         .den_in (dd_ff[j]),
         .rem_in (dr_ff[j]),
         .quo_in (dq_ff[j]),
         .num_ff (dn_ff[j+1]),
         .den_ff (dd_ff[j+1]),
         .rem_ff (dr_ff[j+1]),
         .quo_ff (dq_ff[j+1])
      );
   end

   // gain scaling, products, sum and clamp
   logic [PROD_W-1:0]         radius_ff, radius2_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic [PROD_W+1:0]         r3;
   logic [PROD_W+3:0]         r9;
   logic [GAIN_W-1:0]         gain_in;
   logic signed [GAIN_W+ERR_W:0]  m1_ff;
   logic signed [DGAIN_W+ERR_W+1:0] m2_ff;
   logic signed [39:0]        sum;
   logic                      sat_in;
   logic signed [31:0]        angle_in;
   side_type                  sq, sg;

   always_comb begin
      sq = sb_ff[Q_STAGE];
      sg = sb_ff[Q_STAGE+1];
      r3 = {1'b0, dq_ff[PROD_W], 1'b0} + (PROD_W+2)'(dq_ff[PROD_W]);
      r9 = {1'b0, r3, 1'b0} + (PROD_W+4)'(r3);
      unique case (sq.gsel)
         GAIN_X1P5: gain_in = GAIN_W'(r3 >> 1);
         GAIN_X3:   gain_in = GAIN_W'(r3);
         default:   gain_in = GAIN_W'(r9 >> 1);
      endcase
      sum = 40'(signed'({1'b0, servo_center_ff})) + 40'(m1_ff) + 40'(m1_ff) + 40'(m2_ff);
      sat_in = 1'b1;
      if (sum > 40'sd2147483647)       angle_in = 32'h7FFF_FFFF;
      else if (sum < -40'sd2147483648) angle_in = 32'h8000_0000;
      else begin
         angle_in = sum[31:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         radius_ff  <= dq_ff[PROD_W];
         gain_ff    <= gain_in;
         radius2_ff <= radius_ff;
         m1_ff      <= sg.err * $signed({1'b0, gain_ff});
         m2_ff      <= $signed({1'b0, dgain_ff})
                       * (ERR_W+1)'(signed'(sg.err) - signed'(sg.err_prev));
         rsp_tdata  <= {radius2_ff, angle_in};
         rsp_tuser  <= sat_in;
      end
   end
endmodule
`default_nettype wire

// ===== test/tb_curvature_steering_angle_unit.sv =====
// Self-checking testbench for curvature_steering_angle_unit: directed and random
// sample sets under random stalls on both streams, checked against an inline predictor.
// Depends on csa_pkg and the unit's RTL.
`default_nettype none
module tb_curvature_steering_angle_unit;
   import csa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB = 8;
   localparam longint RADIUS_CAP = 64'd16777215;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   typedef struct {
      logic signed [8:0] err;
      logic signed [8:0] err_prev;
      logic [7:0]        c20;
      logic [7:0]        c27;
      logic [7:0]        c30;
      logic [7:0]        c32;
      logic [7:0]        c37;
   } sample_set_type;

   typedef struct {
      logic signed [31:0] angle;
      logic [23:0]        radius;
      logic               sat;
   } steer_cmd_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [55:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SERVO_CENTER;
   logic [CENTER_W-1:0]  csr_wdata = '0;

   longint        center_r, straight_r, bend_r, dgain_r;
   steer_cmd_type pending_cmds[$];
   int            errors = 0;
   int            beats_sent = 0;
   int            beats_checked = 0;
   int            sat_seen = 0;
   bit            calm = 1'b0;
   int            hold_len = 0;
   int            hold_cnt = 0;

   curvature_steering_angle_unit #(.SAMPLE_BITS(SB)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   function automatic longint isqrt(input longint v);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic steer_cmd_type steer_model(input sample_set_type s);
      steer_cmd_type c;
      longint        m, x1, x2, x3, area, l1, l2, l3, radius, diff, gain, sum;
      m = (64'd1 << SB) - 1;
      x1 = s.c27 & m;
      x2 = s.c32 & m;
      x3 = s.c37 & m;
      area = 5 * (x3 - x1) - 10 * (x2 - x1);
      if (area < 0) area = -area;
      if (area < 1) area = 1;
      l1 = isqrt((x2 - x1) * (x2 - x1) + 25);
      l2 = isqrt((x3 - x1) * (x3 - x1) + 100);
      l3 = isqrt((x2 - x3) * (x2 - x3) + 25);
      radius = (l1 * l2 * l3) / area;
      if (radius > RADIUS_CAP) radius = RADIUS_CAP;
      diff = longint'(s.c20 & m) - longint'(s.c30 & m);
      if (diff < 0) diff = -diff;
      if (diff < straight_r) gain = (3 * radius) >>> 1;
      else if (diff < bend_r) gain = 3 * radius;
      else gain = (9 * radius) >>> 1;
      sum = center_r + 2 * longint'(s.err) * gain
            + dgain_r * (longint'(s.err) - longint'(s.err_prev));
      c.sat = 1'b0;
      if (sum > S32_MAX) begin
         sum = S32_MAX;
         c.sat = 1'b1;
      end else if (sum < S32_MIN) begin
         sum = S32_MIN;
         c.sat = 1'b1;
      end
      c.angle = sum[31:0];
      c.radius = radius[23:0];
      return c;
   endfunction

   // receiver: long hold-offs on request, otherwise random stalls, or always ready when calm
   always @(posedge clock) begin
      if (hold_len > 0) begin
         hold_cnt = hold_len;
         hold_len = 0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 26);
      end
   end

   always @(posedge clock) begin
      steer_cmd_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cmds.size() == 0) begin
            $error("result beat with no expectation: %h", rsp_tdata);
            errors++;
         end else begin
            e = pending_cmds.pop_front();
            beats_checked++;
            if (rsp_tuser) sat_seen++;
            if (rsp_tdata[31:0] !== e.angle) begin
               $error("steering_angle exp %0d got %0d", e.angle, $signed(rsp_tdata[31:0]));
               errors++;
            end
            if (rsp_tdata[55:32] !== e.radius) begin
               $error("radius_estimate exp %0d got %0d", e.radius, rsp_tdata[55:32]);
               errors++;
            end
            if (rsp_tuser !== e.sat) begin
               $error("saturated exp %0b got %0b", e.sat, rsp_tuser);
               errors++;
            end
         end
      end
   end

   task automatic send_beat(input sample_set_type s);
      req_tdata <= {6'd0, s.c37, s.c32, s.c30, s.c27, s.c20, s.err_prev, s.err};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_cmds.push_back(steer_model(s));
      beats_sent++;
      if (!calm && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic send_fields(input int e, input int ep, input int a, input int b,
                              input int c, input int d, input int f);
      sample_set_type s;
      s.err = e[8:0];
      s.err_prev = ep[8:0];
      s.c20 = a[7:0];
      s.c27 = b[7:0];
      s.c30 = c[7:0];
      s.c32 = d[7:0];
      s.c37 = f[7:0];
      send_beat(s);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SERVO_CENTER: center_r = val & 16'hFFFF;
         CSR_STRAIGHT_TH:  straight_r = val & 8'hFF;
         CSR_BEND_TH:      bend_r = val & 8'hFF;
         CSR_DERIV_GAIN:   dgain_r = val & 10'h3FF;
         default: ;
      endcase
   endtask

   task automatic set_regs(input int c, input int st, input int bt, input int dg);
      drain();
      write_reg(CSR_SERVO_CENTER, c);
      write_reg(CSR_STRAIGHT_TH, st);
      write_reg(CSR_BEND_TH, bt);
      write_reg(CSR_DERIV_GAIN, dg);
   endtask

   function automatic sample_set_type rand_set();
      sample_set_type s;
      int             base, slope;
      s.err = 9'($urandom());
      s.err_prev = 9'($urandom());
      if ($urandom_range(0, 1)) begin
         s.c20 = 8'($urandom()); s.c27 = 8'($urandom()); s.c30 = 8'($urandom());
         s.c32 = 8'($urandom()); s.c37 = 8'($urandom());
      end else begin
         // smooth track: near-straight line with small bends
         base = int'($urandom_range(0, 255));
         slope = int'($urandom_range(0, 20)) - 10;
         s.c27 = 8'(base);
         s.c32 = 8'(base + slope + int'($urandom_range(0, 4)) - 2);
         s.c37 = 8'(base + 2 * slope + int'($urandom_range(0, 4)) - 2);
         s.c20 = 8'(base - slope);
         s.c30 = 8'(base - slope + int'($urandom_range(0, 30)) - 15);
      end
      return s;
   endfunction

   task automatic test_directed();
      send_fields(0, 0, 0, 0, 0, 0, 0);
      send_fields(255, 255, 255, 255, 255, 255, 255);
      send_fields(-256, 255, 0, 255, 255, 0, 255);
      send_fields(255, -256, 255, 0, 0, 255, 0);
      // collinear points, positive and negative overflow
      send_fields(255, 0, 0, 0, 255, 127, 254);
      send_fields(-256, 0, 0, 0, 255, 127, 254);
      send_fields(10, 3, 100, 40, 100, 50, 60);
      // gain band edges at reset thresholds
      send_fields(20, -20, 50, 10, 48, 90, 30);
      send_fields(20, -20, 50, 10, 47, 90, 30);
      send_fields(20, -20, 50, 10, 39, 90, 30);
      send_fields(20, -20, 50, 10, 38, 90, 30);
      send_fields(-1, 1, 170, 85, 0, 170, 85);
      send_fields(-128, 127, 1, 2, 4, 8, 16);
   endtask

   task automatic test_config_sweep();
      set_regs(0, 0, 0, 0);
      test_directed();
      set_regs(65535, 255, 255, 1023);
      test_directed();
      set_regs(1000, 200, 5, 7);
      repeat (40) send_beat(rand_set());
      set_regs(2825, 3, 12, 50);
   endtask

   task automatic test_backpressure();
      hold_len = 400;
      repeat (100) send_beat(rand_set());
      drain();
   endtask

   task automatic test_random();
      int n;
      for (n = 0; n < 1500; n++) begin
         if (n == 300) calm = 1'b1;
         if (n == 550) calm = 1'b0;
         if (n % 400 == 399) begin
            set_regs($urandom_range(0, 65535), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 1023));
         end
         send_beat(rand_set());
      end
   endtask

   initial begin
      center_r = 2825;
      straight_r = 3;
      bend_r = 12;
      dgain_r = 50;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_backpressure();
      test_random();
      drain();
      $display("Sent %0d sample sets, checked %0d results (%0d saturated),", beats_sent,
               beats_checked, sat_seen);
      $display("over several register settings, stalls and a long output hold-off.");
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
